/* sv/mhpq_pkg.sv */
// Shared types, sizes and codes for the max-heap priority queue.
package mhpq_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CHILD_W  = IDX_W + 2;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    req_e                     req_type;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] top_value;
    logic [7:0]               entry_count;
    logic                     is_empty;
    status_e                  status;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr0;
    logic [IDX_W-1:0]  raddr1;
  } ram_req_t;

endpackage

/* sv/mhpq_ram.sv */
// Heap storage: one write port, two registered read ports.
module mhpq_ram (
  input  logic                      clk_i,
  input  mhpq_pkg::ram_req_t        ram_req_i,
  output logic [mhpq_pkg::DATA_W-1:0] rdata0_o,
  output logic [mhpq_pkg::DATA_W-1:0] rdata1_o
);

  logic [mhpq_pkg::DATA_W-1:0] mem [mhpq_pkg::CAPACITY];
  logic [mhpq_pkg::DATA_W-1:0] rdata0_q;
  logic [mhpq_pkg::DATA_W-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (ram_req_i.we) begin
      mem[ram_req_i.waddr] <= ram_req_i.wdata;
    end
    rdata0_q <= mem[ram_req_i.raddr0];
    rdata1_q <= mem[ram_req_i.raddr1];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

/* sv/mhpq_ctrl.sv */
// Sift-up / sift-down sequencer working on the heap memory.
module mhpq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  mhpq_pkg::req_t              req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output mhpq_pkg::rsp_t              rsp_o,
  output mhpq_pkg::ram_req_t          ram_req_o,
  input  logic [mhpq_pkg::DATA_W-1:0] rdata0_i,
  input  logic [mhpq_pkg::DATA_W-1:0] rdata1_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_UP,
    S_DN,
    S_FIN,
    S_RESP
  } state_e;

  state_e                         state_q, state_d;
  logic [mhpq_pkg::IDX_W-1:0]     pos_q, pos_d;
  logic [mhpq_pkg::DATA_W-1:0]    hold_q, hold_d;
  logic [mhpq_pkg::CNT_W-1:0]     count_q, count_d;
  logic [mhpq_pkg::DATA_W-1:0]    top_q, top_d;
  logic [mhpq_pkg::DATA_W-1:0]    removed_q, removed_d;
  mhpq_pkg::status_e              status_q, status_d;

  logic [mhpq_pkg::IDX_W-1:0]     cnt_idx, last_idx, par_idx, grand_idx, pick_idx;
  logic [mhpq_pkg::CHILD_W-1:0]   c1, c2, nc1, nc2, n_ext;
  logic                           pick2;
  logic [mhpq_pkg::DATA_W-1:0]    pick_val;

  assign cnt_idx   = count_q[mhpq_pkg::IDX_W-1:0];
  assign last_idx  = cnt_idx - mhpq_pkg::IDX_W'(1);
  assign par_idx   = (pos_q - mhpq_pkg::IDX_W'(1)) >> 1;
  assign grand_idx = (par_idx - mhpq_pkg::IDX_W'(1)) >> 1;
  assign n_ext     = mhpq_pkg::CHILD_W'(count_q);
  assign c1        = {1'b0, pos_q, 1'b1};
  assign c2        = c1 + mhpq_pkg::CHILD_W'(1);
  assign pick2     = (c2 < n_ext) && ($signed(rdata1_i) > $signed(rdata0_i));
  assign pick_idx  = pick2 ? c2[mhpq_pkg::IDX_W-1:0] : c1[mhpq_pkg::IDX_W-1:0];
  assign pick_val  = pick2 ? rdata1_i : rdata0_i;
  assign nc1       = {1'b0, pick_idx, 1'b1};
  assign nc2       = nc1 + mhpq_pkg::CHILD_W'(1);

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    hold_d    = hold_q;
    count_d   = count_q;
    removed_d = removed_q;
    status_d  = status_q;
    ram_req_o = '{we: 1'b0, waddr: pos_q, wdata: hold_q, raddr0: '0, raddr1: '0};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          removed_d = '0;
          status_d  = mhpq_pkg::ST_OK;
          if (req_i.req_type == mhpq_pkg::REQ_INSERT) begin
            if (count_q == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)) begin
              status_d = mhpq_pkg::ST_FULL;
              state_d  = S_RESP;
            end else begin
              hold_d  = req_i.item_value;
              pos_d   = cnt_idx;
              count_d = count_q + mhpq_pkg::CNT_W'(1);
              if (count_q == '0) begin
                state_d = S_FIN;
              end else begin
                ram_req_o.raddr0 = (cnt_idx - mhpq_pkg::IDX_W'(1)) >> 1;
                state_d          = S_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = mhpq_pkg::ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              removed_d = top_q;
              count_d   = count_q - mhpq_pkg::CNT_W'(1);
              pos_d     = '0;
              if (count_q == mhpq_pkg::CNT_W'(1)) begin
                state_d = S_RESP;
              end else begin
                ram_req_o.raddr0 = last_idx;
                state_d          = S_LAST;
              end
            end
          end
        end
      end
      S_LAST: begin
        hold_d = rdata0_i;
        if (count_q > mhpq_pkg::CNT_W'(1)) begin
          ram_req_o.raddr0 = c1[mhpq_pkg::IDX_W-1:0];
          ram_req_o.raddr1 = c2[mhpq_pkg::IDX_W-1:0];
          state_d          = S_DN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_UP: begin
        if ($signed(hold_q) > $signed(rdata0_i)) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = rdata0_i;
          pos_d           = par_idx;
          if (par_idx == '0) begin
            state_d = S_FIN;
          end else begin
            ram_req_o.raddr0 = grand_idx;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN: begin
        if ($signed(pick_val) > $signed(hold_q)) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = pick_val;
          pos_d           = pick_idx;
          if (nc1 < n_ext) begin
            ram_req_o.raddr0 = nc1[mhpq_pkg::IDX_W-1:0];
            ram_req_o.raddr1 = nc2[mhpq_pkg::IDX_W-1:0];
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ram_req_o.we = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    top_d = top_q;
    if (ram_req_o.we && (ram_req_o.waddr == '0)) begin
      top_d = ram_req_o.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      status_q <= mhpq_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    hold_q    <= hold_d;
    top_q     <= top_d;
    removed_q <= removed_d;
  end

  assign rsp_o.removed_value = removed_q;
  assign rsp_o.top_value     = (count_q == '0) ? '0 : top_q;
  assign rsp_o.entry_count   = 8'(count_q);
  assign rsp_o.is_empty      = (count_q == '0);
  assign rsp_o.status        = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_count_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_valid_i && req_ready_o) |=> $stable(count_q))
    else $error("entry count changed without a transaction");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RESP) |-> !ram_req_o.we)
    else $error("heap memory written outside a sift");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && req_i.req_type == mhpq_pkg::REQ_INSERT &&
     count_q == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
    |=> (status_q == mhpq_pkg::ST_FULL && state_q == S_RESP))
    else $error("insert into full heap not refused");

  a_empty_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && req_i.req_type == mhpq_pkg::REQ_REMOVE &&
     count_q == '0) |=> (status_q == mhpq_pkg::ST_EMPTY && count_q == '0))
    else $error("remove from empty heap not refused");

endmodule

/* sv/max_heap_priority_queue.sv */
// Top level of the max-heap priority queue: sequencer, heap memory, response register.
// One transaction at a time: an insert compares with one parent per step, and a remove
// with one child pair per step. Removing the last entry, or a refused request, skips
// the sift. The sift is a read-compare-write loop around the single heap memory, whose
// reads return in the cycle after the address. A finished response sits in an output
// register, so the next request is taken while it waits to be collected.
module max_heap_priority_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  mhpq_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output mhpq_pkg::rsp_t rsp_o
);

  mhpq_pkg::ram_req_t          ram_req;
  logic [mhpq_pkg::DATA_W-1:0] rdata0, rdata1;
  logic                        ctrl_rsp_valid, ctrl_rsp_ready;
  mhpq_pkg::rsp_t              ctrl_rsp;
  logic                        rsp_valid_q;
  mhpq_pkg::rsp_t              rsp_q;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (ctrl_rsp_valid),
    .rsp_ready_i (ctrl_rsp_ready),
    .rsp_o       (ctrl_rsp),
    .ram_req_o   (ram_req),
    .rdata0_i    (rdata0),
    .rdata1_i    (rdata1)
  );

  mhpq_ram u_ram (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rdata0_o  (rdata0),
    .rdata1_o  (rdata1)
  );

  assign ctrl_rsp_ready = !rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctrl_rsp_ready) begin
      rsp_valid_q <= ctrl_rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_rsp_valid && ctrl_rsp_ready) begin
      rsp_q <= ctrl_rsp;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* bench/max_heap_priority_queue_tb.sv */
// Self-checking testbench for the max-heap priority queue, checked against a built-in heap model.
`timescale 1ns / 100ps

module max_heap_priority_queue_tb;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           req_valid_i = 1'b0;
  logic           req_ready_o;
  mhpq_pkg::req_t req_i       = '0;
  logic           rsp_valid_o;
  logic           rsp_ready_i = 1'b0;
  mhpq_pkg::rsp_t rsp_o;

  max_heap_priority_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  logic signed [mhpq_pkg::DATA_W-1:0] heap_mem [mhpq_pkg::CAPACITY];
  int heap_cnt = 0;

  mhpq_pkg::req_t req_pending [$];
  mhpq_pkg::rsp_t rsp_expect [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int gen_count      = 0;
  int err_count      = 0;
  int stall_cycles   = 0;

  function automatic mhpq_pkg::rsp_t heap_apply(mhpq_pkg::req_t rq);
    mhpq_pkg::rsp_t r;
    int pos, c1, c2, pick;
    bit moving;
    logic signed [mhpq_pkg::DATA_W-1:0] tmp;
    r = '0;
    r.status = mhpq_pkg::ST_OK;
    if (rq.req_type == mhpq_pkg::REQ_INSERT) begin
      if (heap_cnt >= mhpq_pkg::CAPACITY) begin
        r.status = mhpq_pkg::ST_FULL;
      end else begin
        heap_mem[heap_cnt] = rq.item_value;
        pos = heap_cnt;
        while (pos > 0 && heap_mem[pos] > heap_mem[(pos - 1) / 2]) begin
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[(pos - 1) / 2];
          heap_mem[(pos - 1) / 2] = tmp;
          pos = (pos - 1) / 2;
        end
        heap_cnt++;
      end
    end else begin
      if (heap_cnt == 0) begin
        r.status = mhpq_pkg::ST_EMPTY;
      end else begin
        r.removed_value = heap_mem[0];
        heap_cnt--;
        heap_mem[0] = heap_mem[heap_cnt];
        pos = 0;
        moving = 1'b1;
        while (moving) begin
          c1 = 2 * pos + 1;
          c2 = c1 + 1;
          if (c1 >= heap_cnt) begin
            moving = 1'b0;
          end else begin
            pick = c1;
            // first child wins ties
            if (c2 < heap_cnt && heap_mem[c2] > heap_mem[c1]) pick = c2;
            if (heap_mem[pick] > heap_mem[pos]) begin
              tmp = heap_mem[pick];
              heap_mem[pick] = heap_mem[pos];
              heap_mem[pos] = tmp;
              pos = pick;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
    end
    r.top_value   = (heap_cnt != 0) ? heap_mem[0] : '0;
    r.entry_count = 8'(heap_cnt);
    r.is_empty    = (heap_cnt == 0);
    return r;
  endfunction

  task automatic check_rsp(mhpq_pkg::rsp_t want, mhpq_pkg::rsp_t got);
    if (got.removed_value !== want.removed_value) begin
      $error("removed_value: expected %0d, got %0d", want.removed_value, got.removed_value);
      err_count++;
    end
    if (got.top_value !== want.top_value) begin
      $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
      err_count++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      err_count++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
      err_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      err_count++;
    end
  endtask

  function automatic logic signed [mhpq_pkg::DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom;
    if (sel < 70) return 32'($urandom_range(16)) - 32'd8;
    if (sel < 85) begin
      case ($urandom_range(3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (sel < 92) return 32'sh7fffffff - 32'($urandom_range(3));
    return 32'sh80000000 + 32'($urandom_range(3));
  endfunction

  task automatic push_item(mhpq_pkg::req_e kind, logic signed [mhpq_pkg::DATA_W-1:0] value);
    mhpq_pkg::req_t rq;
    rq.req_type   = kind;
    rq.item_value = value;
    req_pending.push_back(rq);
    if (kind == mhpq_pkg::REQ_INSERT) begin
      if (gen_count < mhpq_pkg::CAPACITY) gen_count++;
    end else if (gen_count > 0) begin
      gen_count--;
    end
  endtask

  // bursts leaning toward growth, shrinkage or a mix
  task automatic push_bursts(int total);
    int left, len, ins_pct;
    left = total;
    while (left > 0) begin
      len = $urandom_range(60, 10);
      if (len > left) len = left;
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      repeat (len) begin
        if ($urandom_range(99) < ins_pct) push_item(mhpq_pkg::REQ_INSERT, pick_value());
        else push_item(mhpq_pkg::REQ_REMOVE, pick_value());
      end
      left -= len;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (req_pending.size() != 0 || req_valid_i || rsp_expect.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
    end else if (!req_valid_i || req_ready_o) begin
      if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_valid_i <= 1'b1;
        req_i       <= req_pending.pop_front();
      end else begin
        req_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (rsp_expect.size() == 0) begin
          $error("unexpected transaction: %p", rsp_o);
          err_count++;
        end else begin
          check_rsp(rsp_expect.pop_front(), rsp_o);
        end
      end
      if (req_valid_i && req_ready_o) rsp_expect.push_back(heap_apply(req_i));
      rsp_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i) ||
          (req_pending.size() == 0 && !req_valid_i && rsp_expect.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_item(mhpq_pkg::REQ_REMOVE, 32'sd5);
    push_item(mhpq_pkg::REQ_INSERT, 32'sd0);
    push_item(mhpq_pkg::REQ_INSERT, 32'sh7fffffff);
    push_item(mhpq_pkg::REQ_INSERT, 32'sh80000000);
    push_item(mhpq_pkg::REQ_INSERT, -32'sd1);
    push_item(mhpq_pkg::REQ_INSERT, 32'sd1);
    push_item(mhpq_pkg::REQ_INSERT, 32'sd5);
    push_item(mhpq_pkg::REQ_INSERT, 32'sd5);
    push_item(mhpq_pkg::REQ_INSERT, 32'sh7fffffff);
    repeat (9) push_item(mhpq_pkg::REQ_REMOVE, pick_value());
    push_item(mhpq_pkg::REQ_INSERT, 32'sh80000000);
    push_item(mhpq_pkg::REQ_INSERT, 32'sh80000000);
    push_item(mhpq_pkg::REQ_REMOVE, 32'sh7fffffff);
    push_item(mhpq_pkg::REQ_REMOVE, 32'sh80000000);
    push_bursts(150);
    // sender holds off until every transaction has returned
    wait_idle();

    send_idle_pct  = 60;
    recv_stall_pct = 0;
    while (gen_count < mhpq_pkg::CAPACITY) push_item(mhpq_pkg::REQ_INSERT, pick_value());
    repeat (3) push_item(mhpq_pkg::REQ_INSERT, pick_value());
    push_bursts(40);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 60;
    push_bursts(120);
    while (gen_count > 0) push_item(mhpq_pkg::REQ_REMOVE, pick_value());
    repeat (2) push_item(mhpq_pkg::REQ_REMOVE, pick_value());
    wait_idle();

    send_idle_pct  = 34;
    recv_stall_pct = 34;
    push_bursts(170);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && rsp_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
